// ===== rtl/bba_pkg.sv =====
// Bitmap block allocator: shared types, codes and default sizes.
// No dependencies; every other file of the block but bba_ram refers to it.
package bba_pkg;

    localparam int ADDR_W   = 27;
    localparam int LEN_W    = 16;
    localparam int CFG_W    = 16;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 16;

    localparam int BLOCK_BYTES_DEF = 4096;
    localparam int MAX_BLOCKS_DEF  = 32768;
    localparam int WORD_BITS_DEF   = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC_ONE = 3'd0,
        OP_ALLOC_RUN = 3'd1,
        OP_FREE_ONE  = 3'd2,
        OP_FREE_RUN  = 3'd3,
        OP_RESERVE   = 3'd4,
        OP_TEST      = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_DECODE,
        S_SRCH_RD,
        S_SRCH_EV,
        S_APP_RD,
        S_APP_WR,
        S_TEST_RD,
        S_TEST_EV,
        S_RESP
    } state_t;

    typedef struct packed {
        logic    req_load;
        logic    rd_en;
        logic    rd_test;
        logic    srch_step;
        logic    app_req;
        logic    app_srch;
        logic    app_wr;
        logic    test_load;
        logic    clr_wr;
        logic    status_wr;
        status_t status_val;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            len_zero;
        logic            range_bad;
        logic            test_bad;
        logic            hit;
        logic            srch_end;
        logic            app_last;
        logic            clr_last;
    } stat_t;

endpackage

// ===== rtl/bba_if.sv =====
// Request and response channel interfaces of the bitmap block allocator.
// Depends on bba_pkg for field widths.
interface bba_req_if;
    logic                        valid;
    logic                        ready;
    logic [bba_pkg::OP_W-1:0]    op;
    logic [bba_pkg::ADDR_W-1:0]  address;
    logic [bba_pkg::LEN_W-1:0]   run_length;

    modport source (output valid, output op, output address, output run_length, input ready);
    modport sink (input valid, input op, input address, input run_length, output ready);
endinterface

interface bba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bba_pkg::STATUS_W-1:0]  status;
    logic [bba_pkg::ADDR_W-1:0]    block_address;
    logic                          is_used;
    logic [bba_pkg::USED_W-1:0]    used_total;

    modport source (output valid, output status, output block_address, output is_used,
                    output used_total, input ready);
    modport sink (input valid, input status, input block_address, input is_used,
                  input used_total, output ready);
endinterface

// ===== rtl/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/bba_ctrl.sv =====
// Allocator controller: sequences clear pass, search, range update and test.
// Depends on bba_pkg; drives bba_dp through cmd_t and watches stat_t.
module bba_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  bba_pkg::stat_t  stat,
    output bba_pkg::cmd_t   cmd
);

    bba_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bba_pkg::S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bba_pkg::S_CLR:
            begin
                if (stat.clr_last)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bba_pkg::S_DECODE;
                end
            end
            bba_pkg::S_DECODE:
            begin
                priority case (stat.op)
                    bba_pkg::OP_ALLOC_ONE, bba_pkg::OP_ALLOC_RUN:
                        state_next = stat.len_zero ? bba_pkg::S_RESP : bba_pkg::S_SRCH_RD;
                    bba_pkg::OP_FREE_ONE, bba_pkg::OP_FREE_RUN, bba_pkg::OP_RESERVE:
                        state_next = (stat.len_zero || stat.range_bad) ? bba_pkg::S_RESP
                                                                       : bba_pkg::S_APP_RD;
                    bba_pkg::OP_TEST:
                        state_next = stat.test_bad ? bba_pkg::S_RESP : bba_pkg::S_TEST_RD;
                    default:
                        state_next = bba_pkg::S_RESP;
                endcase
            end
            bba_pkg::S_SRCH_RD:
                state_next = bba_pkg::S_SRCH_EV;
            bba_pkg::S_SRCH_EV:
            begin
                if (stat.hit)
                begin
                    state_next = bba_pkg::S_APP_RD;
                end
                else if (stat.srch_end)
                begin
                    state_next = bba_pkg::S_RESP;
                end
                else
                begin
                    state_next = bba_pkg::S_SRCH_RD;
                end
            end
            bba_pkg::S_APP_RD:
                state_next = bba_pkg::S_APP_WR;
            bba_pkg::S_APP_WR:
                state_next = stat.app_last ? bba_pkg::S_RESP : bba_pkg::S_APP_RD;
            bba_pkg::S_TEST_RD:
                state_next = bba_pkg::S_TEST_EV;
            bba_pkg::S_TEST_EV:
                state_next = bba_pkg::S_RESP;
            bba_pkg::S_RESP:
            begin
                if (out_ready)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default:
                state_next = bba_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd.status_val = bba_pkg::ST_OK;
        unique case (state_reg)
            bba_pkg::S_CLR:
                cmd.clr_wr = 1'b1;
            bba_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.req_load = in_valid;
            end
            bba_pkg::S_DECODE:
            begin
                priority case (stat.op)
                    bba_pkg::OP_ALLOC_ONE, bba_pkg::OP_ALLOC_RUN:
                    begin
                        cmd.status_wr  = stat.len_zero;
                        cmd.status_val = bba_pkg::ST_RANGE;
                    end
                    bba_pkg::OP_FREE_ONE, bba_pkg::OP_FREE_RUN, bba_pkg::OP_RESERVE:
                    begin
                        cmd.status_wr  = stat.len_zero || stat.range_bad;
                        cmd.status_val = bba_pkg::ST_RANGE;
                        cmd.app_req    = !(stat.len_zero || stat.range_bad);
                    end
                    bba_pkg::OP_TEST:
                    begin
                        cmd.status_wr  = stat.test_bad;
                        cmd.status_val = bba_pkg::ST_RANGE;
                    end
                    default:
                        cmd.status_wr = 1'b0;
                endcase
            end
            bba_pkg::S_SRCH_RD:
                cmd.rd_en = 1'b1;
            bba_pkg::S_SRCH_EV:
            begin
                cmd.app_srch   = stat.hit;
                cmd.srch_step  = !stat.hit;
                cmd.status_wr  = !stat.hit && stat.srch_end;
                cmd.status_val = bba_pkg::ST_NOSPACE;
            end
            bba_pkg::S_APP_RD:
                cmd.rd_en = 1'b1;
            bba_pkg::S_APP_WR:
                cmd.app_wr = 1'b1;
            bba_pkg::S_TEST_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_test = 1'b1;
            end
            bba_pkg::S_TEST_EV:
                cmd.test_load = 1'b1;
            bba_pkg::S_RESP:
                out_valid = 1'b1;
            default:
                cmd.status_wr = 1'b0;
        endcase
    end

endmodule

// ===== rtl/bba_dp.sv =====
// Allocator datapath: bitmap RAM, word-wide run search, range update, counters.
// Depends on bba_pkg and bba_ram; commanded by bba_ctrl.
module bba_dp #(
    parameter int BLOCK_BYTES = bba_pkg::BLOCK_BYTES_DEF,
    parameter int MAX_BLOCKS  = bba_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BITS   = bba_pkg::WORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bba_pkg::OP_W-1:0]      op,
    input  logic [bba_pkg::ADDR_W-1:0]    address,
    input  logic [bba_pkg::LEN_W-1:0]     run_length,
    input  logic                          cfg_we,
    input  logic [bba_pkg::CFG_W-1:0]     cfg_wdata,
    input  bba_pkg::cmd_t                 cmd,
    output bba_pkg::stat_t                stat,
    output logic [bba_pkg::STATUS_W-1:0]  status,
    output logic [bba_pkg::ADDR_W-1:0]    block_address,
    output logic                          is_used,
    output logic [bba_pkg::USED_W-1:0]    used_total
);

    localparam int OFF_W     = $clog2(BLOCK_BYTES);
    localparam int BLK_W     = bba_pkg::ADDR_W - OFF_W;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
    localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
    localparam int MX1       = BLK_W > bba_pkg::LEN_W ? BLK_W : bba_pkg::LEN_W;
    localparam int MX2       = CNT_W > bba_pkg::CFG_W ? CNT_W : bba_pkg::CFG_W;
    localparam int SUM_W     = (MX1 > MX2 ? MX1 : MX2) + 1;
    localparam int BP_RST    = MAX_BLOCKS > 65535 ? 65535 : MAX_BLOCKS;

    logic [bba_pkg::CFG_W-1:0] bp_reg;
    bba_pkg::op_t              op_reg;
    logic [BLK_W-1:0]          blk_reg;
    logic [bba_pkg::LEN_W-1:0] len_reg;
    logic [WA_W-1:0]           widx_reg;
    logic [WA_W-1:0]           clr_reg;
    logic [SUM_W-1:0]          got_reg;
    logic [SUM_W-1:0]          rs_reg;
    logic [SUM_W-1:0]          re_reg;
    logic                      val_reg;
    logic [CNT_W-1:0]          cnt_reg;
    bba_pkg::status_t          status_reg;
    logic [bba_pkg::ADDR_W-1:0] baddr_reg;
    logic                      used_reg;

    logic [SUM_W-1:0]     lim;
    logic [SUM_W-1:0]     base;
    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] free_v;
    logic [BIT_W:0]       rl [BIT_W+1][WORD_BITS];
    logic [WORD_BITS-1:0] all_v;
    logic [WORD_BITS-1:0] hit_v;
    logic [SUM_W-1:0]     thr_all;
    logic                 hit;
    logic [BIT_W-1:0]     hj;
    logic [SUM_W-1:0]     got_next;
    logic [SUM_W-1:0]     start_c;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] new_word;
    logic [WORD_BITS-1:0] flip;
    logic [BIT_W:0]       pc [BIT_W+1][WORD_BITS];
    logic [WA_W-1:0]      raddr;
    logic [WA_W-1:0]      waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [bba_pkg::LEN_W-1:0] len_in;

    assign lim  = (SUM_W'(bp_reg) < SUM_W'(MAX_BLOCKS)) ? SUM_W'(bp_reg) : SUM_W'(MAX_BLOCKS);
    assign base = SUM_W'(widx_reg) << BIT_W;

    assign raddr = cmd.rd_test ? WA_W'(blk_reg >> BIT_W) : widx_reg;
    assign waddr = cmd.clr_wr ? clr_reg : widx_reg;
    assign wdata = cmd.clr_wr ? '1 : new_word;

    bba_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(MAP_WORDS)
    ) u_map (
        .clk  (clk),
        .we   (cmd.clr_wr | cmd.app_wr),
        .waddr(waddr),
        .wdata(wdata),
        .re   (cmd.rd_en),
        .raddr(raddr),
        .rdata(rdata)
    );

    // run length of free blocks ending at each bit, by doubling
    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            free_v[j] = !rdata[j] && ((base + SUM_W'(j)) < lim);
            rl[0][j]  = (BIT_W+1)'(free_v[j]);
        end
        for (int s = 0; s < BIT_W; s++)
        begin
            for (int j = 0; j < WORD_BITS; j++)
            begin
                if (j >= (1 << s) && rl[s][j] == (BIT_W+1)'(1 << s))
                begin
                    rl[s+1][j] = rl[s][j] + rl[s][j - (1 << s)];
                end
                else
                begin
                    rl[s+1][j] = rl[s][j];
                end
            end
        end
    end

    assign thr_all = SUM_W'(len_reg) - got_reg;

    always_comb
    begin
        hit = 1'b0;
        hj  = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            all_v[j] = rl[BIT_W][j] == (BIT_W+1)'(j + 1);
            hit_v[j] = all_v[j] ? (SUM_W'(rl[BIT_W][j]) >= thr_all)
                                : (SUM_W'(rl[BIT_W][j]) >= SUM_W'(len_reg));
        end
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (hit_v[j])
            begin
                hit = 1'b1;
                hj  = BIT_W'(j);
            end
        end
    end

    assign got_next = all_v[WORD_BITS-1] ? got_reg + SUM_W'(rl[BIT_W][WORD_BITS-1])
                                         : SUM_W'(rl[BIT_W][WORD_BITS-1]);
    assign start_c  = base + SUM_W'(hj) + SUM_W'(1) - SUM_W'(len_reg);

    // range update of one word and count of flipped bits
    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            mask[j] = ((base + SUM_W'(j)) >= rs_reg) && ((base + SUM_W'(j)) < re_reg);
        end
        new_word = val_reg ? (rdata | mask) : (rdata & ~mask);
        flip     = mask & (rdata ^ {WORD_BITS{val_reg}});
        for (int i = 0; i < WORD_BITS; i++)
        begin
            pc[0][i] = (BIT_W+1)'(flip[i]);
        end
        for (int l = 0; l < BIT_W; l++)
        begin
            for (int i = 0; i < WORD_BITS; i++)
            begin
                if (i < (WORD_BITS >> (l + 1)))
                begin
                    pc[l+1][i] = pc[l][2*i] + pc[l][2*i+1];
                end
                else
                begin
                    pc[l+1][i] = '0;
                end
            end
        end
    end

    assign len_in = (bba_pkg::op_t'(op) == bba_pkg::OP_ALLOC_ONE ||
                     bba_pkg::op_t'(op) == bba_pkg::OP_FREE_ONE) ? bba_pkg::LEN_W'(1)
                                                                 : run_length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_reg  <= bba_pkg::CFG_W'(BP_RST);
            cnt_reg <= CNT_W'(MAX_BLOCKS);
            clr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                bp_reg <= cfg_wdata;
            end
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + WA_W'(1);
            end
            if (cmd.app_wr)
            begin
                cnt_reg <= val_reg ? cnt_reg + CNT_W'(pc[BIT_W][0])
                                   : cnt_reg - CNT_W'(pc[BIT_W][0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            op_reg     <= bba_pkg::op_t'(op);
            blk_reg    <= address[bba_pkg::ADDR_W-1:OFF_W];
            len_reg    <= len_in;
            widx_reg   <= '0;
            got_reg    <= '0;
            status_reg <= bba_pkg::ST_OK;
            baddr_reg  <= '0;
            used_reg   <= 1'b0;
        end
        if (cmd.status_wr)
        begin
            status_reg <= cmd.status_val;
        end
        if (cmd.srch_step)
        begin
            widx_reg <= widx_reg + WA_W'(1);
            got_reg  <= got_next;
        end
        if (cmd.app_req)
        begin
            rs_reg   <= SUM_W'(blk_reg);
            re_reg   <= SUM_W'(blk_reg) + SUM_W'(len_reg);
            widx_reg <= WA_W'(blk_reg >> BIT_W);
            val_reg  <= op_reg == bba_pkg::OP_RESERVE;
        end
        if (cmd.app_srch)
        begin
            rs_reg    <= start_c;
            re_reg    <= start_c + SUM_W'(len_reg);
            widx_reg  <= WA_W'(start_c >> BIT_W);
            val_reg   <= 1'b1;
            baddr_reg <= bba_pkg::ADDR_W'({start_c, OFF_W'(0)});
        end
        if (cmd.app_wr)
        begin
            widx_reg <= widx_reg + WA_W'(1);
        end
        if (cmd.test_load)
        begin
            used_reg <= rdata[blk_reg[BIT_W-1:0]];
        end
    end

    assign stat.op        = op_reg;
    assign stat.len_zero  = len_reg == '0;
    assign stat.range_bad = (SUM_W'(blk_reg) + SUM_W'(len_reg)) > lim;
    assign stat.test_bad  = SUM_W'(blk_reg) >= lim;
    assign stat.hit       = hit;
    assign stat.srch_end  = (base + SUM_W'(WORD_BITS)) >= lim;
    assign stat.app_last  = (base + SUM_W'(WORD_BITS)) >= re_reg;
    assign stat.clr_last  = clr_reg == WA_W'(MAP_WORDS - 1);

    assign status        = status_reg;
    assign block_address = baddr_reg;
    assign is_used       = used_reg;
    assign used_total    = bba_pkg::USED_W'(cnt_reg);

endmodule

// ===== rtl/bitmap_block_allocator_core.sv =====
// Bitmap block allocator, first fit, one request at a time.
// Alloc: each bitmap word searched, up to 1024, is read from RAM then evaluated; then
// each run word is read then written; free/reserve: likewise per word; test: one read.
// Result is held until taken; next request accepted after the result beat.
// Reset (rst_n low, async) starts a pass over every bitmap word setting every block used;
// no request is accepted during it. Depends on bba_pkg, bba_if, bba_ctrl, bba_dp.
module bitmap_block_allocator_core #(
    parameter int BLOCK_BYTES = bba_pkg::BLOCK_BYTES_DEF,
    parameter int MAX_BLOCKS  = bba_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BITS   = bba_pkg::WORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    bba_req_if.sink                   req,
    bba_rsp_if.source                 rsp,
    input  logic                      cfg_we,
    input  logic [bba_pkg::CFG_W-1:0] cfg_wdata
);

    bba_pkg::cmd_t  cmd;
    bba_pkg::stat_t stat;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .out_valid(rsp.valid),
        .out_ready(rsp.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bba_dp #(
        .BLOCK_BYTES(BLOCK_BYTES),
        .MAX_BLOCKS (MAX_BLOCKS),
        .WORD_BITS  (WORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (req.op),
        .address      (req.address),
        .run_length   (req.run_length),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .stat         (stat),
        .status       (rsp.status),
        .block_address(rsp.block_address),
        .is_used      (rsp.is_used),
        .used_total   (rsp.used_total)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("request taken while a result is pending");

    a_beat_once: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.ready |=> !rsp.valid)
        else $error("result beat repeated");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != bba_pkg::ST_OK |-> rsp.block_address == '0)
        else $error("failed request carries an address");

    a_used_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.is_used |-> rsp.status == bba_pkg::ST_OK)
        else $error("used flag on a failed request");
`endif

endmodule
